/* hdl/ocp_pkg.sv */
`default_nettype none
package ocp_pkg;

  // Largest tour length the list of cells can hold.
  localparam int MAX_NODES = 256;

  // Width of the ordinal and node fields on the channels.
  localparam int ORD_W = 9;

  // Width of a stored node number, a count or a position (holds MAX_NODES itself).
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  // Width of a cell index.
  localparam int IDX_W = $clog2(MAX_NODES);

  // Compare width that holds both an ordinal and a count.
  localparam int CMP_W = (CNT_W > ORD_W) ? CNT_W + 1 : ORD_W + 1;

  // Tour length after reset.
  localparam int RESET_COUNT = (256 > MAX_NODES) ? MAX_NODES : 256;

  // Register index of node_count.
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef logic [CNT_W-1:0] node_val_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic             refill;
    logic             shift;
    logic [CNT_W-1:0] count;
    logic [ORD_W-1:0] ordinal;
  } cell_ctl_t;

  // Keep a written tour length within 2..MAX_NODES.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [ORD_W-1:0] w);
    logic [CNT_W-1:0] res;
    if (int'(w) < 2) begin
      res = CNT_W'(2);
    end else if (int'(w) > MAX_NODES) begin
      res = CNT_W'(MAX_NODES);
    end else begin
      res = CNT_W'(w);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/ocp_if.sv */
`default_nettype none
interface ocp_in_if import ocp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ORD_W-1:0] ordinal;

  modport source (output valid, output ordinal, input ready);
  modport sink   (input valid, input ordinal, output ready);
endinterface

interface ocp_out_if import ocp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ORD_W-1:0] node;
  logic             last_of_tour;
  logic             bad_ordinal;

  modport source (output valid, output node, output last_of_tour, output bad_ordinal,
                  input ready);
  modport sink   (input valid, input node, input last_of_tour, input bad_ordinal,
                  output ready);
endinterface
`default_nettype wire

/* hdl/ocp_cell.sv */
`default_nettype none
module ocp_cell import ocp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] own_idx,
  input  wire node_val_t        from_next,
  output node_val_t             val,
  output node_val_t             tap
);

  node_val_t        val_r;
  node_val_t        val_nxt;
  logic [CMP_W-1:0] pos1;
  logic [CMP_W-1:0] ord_ext;
  logic             hit;
  logic             take_next;
  node_val_t        fill_val;
  node_val_t        rst_val;

  // One-based position of this cell within the list.
  assign pos1      = CMP_W'(own_idx) + CMP_W'(1);
  assign ord_ext   = CMP_W'(ctl.ordinal);
  assign hit       = (ord_ext == pos1);
  // Every cell at or after the chosen one takes its neighbor's value.
  assign take_next = ctl.shift && (ord_ext <= pos1);

  assign fill_val = (CMP_W'(own_idx) < CMP_W'(ctl.count)) ? CNT_W'(pos1) : '0;
  assign rst_val  = (int'(own_idx) < RESET_COUNT) ? CNT_W'(pos1) : '0;

  always_comb begin
    if (ctl.refill) begin
      val_nxt = fill_val;
    end else if (take_next) begin
      val_nxt = from_next;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= rst_val;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
  assign tap = hit ? val_r : '0;

endmodule
`default_nettype wire

/* hdl/ordinal_code_to_permutation_unit.sv */
`default_nettype none
// Channel     | Direction | Payload                                | Handshake
// in_chan     | sink      | ordinal[8:0]                           | valid / ready
// out_chan    | source    | node[8:0], last_of_tour, bad_ordinal   | valid / ready
// cfg (APB)   | slave     | node_count at byte address 0           | psel / penable
//
// One request is taken per clock cycle while the output register can take it; its result
// appears in the output register on the next cycle. The rate is set by the row of list
// cells, which select and shift the whole remaining-node list in the same cycle.
// Reset (rst_n, synchronous, active low) loads a tour of 256 nodes (capped at MAX_NODES).
// A stalled output blocks new requests only while the output register is full and
// out_chan.ready is low.
module ordinal_code_to_permutation_unit import ocp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ocp_in_if.sink           in_chan,
  ocp_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Tour state: the tour length, the number of nodes still in the list and the number
  // of results already produced in this tour.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;

  // Output register.
  logic             out_valid_r;
  logic [ORD_W-1:0] out_node_r;
  logic             out_last_r;
  logic             out_bad_r;

  logic             take;
  logic             cfg_wr;
  logic             bad;
  logic             last;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] new_count;
  node_val_t        picked;
  cell_ctl_t        ctl;

  node_val_t        cell_val [MAX_NODES];
  node_val_t        cell_tap [MAX_NODES];
  node_val_t        cell_in  [MAX_NODES];

  // The configuration port decodes the word address only; a write to the one register
  // restarts the tour.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(count_r) : '0;
  assign new_count = clamp_count(pwdata[ORD_W-1:0]);

  // A new request enters whenever the output register is free or being emptied.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && in_chan.ready;

  // An ordinal of zero or past the end of the live list is rejected; it still counts
  // as one step of the tour.
  assign bad     = (in_chan.ordinal == '0) ||
                   (CMP_W'(in_chan.ordinal) > CMP_W'(live_r));
  assign pos_inc = pos_r + CNT_W'(1);
  assign last    = (pos_inc >= count_r);

  // Broadcast to the cells. The end of a tour refills the list instead of shifting.
  always_comb begin
    ctl.refill  = cfg_wr || (take && last);
    ctl.shift   = take && !bad;
    ctl.count   = cfg_wr ? new_count : count_r;
    ctl.ordinal = in_chan.ordinal;
  end

  // The row of cells: each hands its value to the one before it when the list closes
  // the gap left by the chosen node, and the last cell takes an empty entry.
  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    if (g == MAX_NODES - 1) begin : g_end
      assign cell_in[g] = '0;
    end else begin : g_mid
      assign cell_in[g] = cell_val[g+1];
    end

    ocp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .own_idx   (IDX_W'(g)),
      .from_next (cell_in[g]),
      .val       (cell_val[g]),
      .tap       (cell_tap[g])
    );
  end

  // Exactly one cell matches a good ordinal, so the taps combine by OR.
  always_comb begin
    picked = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      picked = picked | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    live_nxt  = live_r;
    pos_nxt   = pos_r;
    if (cfg_wr) begin
      count_nxt = new_count;
      live_nxt  = new_count;
      pos_nxt   = '0;
    end else if (take) begin
      if (last) begin
        live_nxt = count_r;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_inc;
        if (!bad) begin
          live_nxt = live_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(RESET_COUNT);
      live_r      <= CNT_W'(RESET_COUNT);
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      live_r  <= live_nxt;
      pos_r   <= pos_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_node_r <= bad ? '0 : ORD_W'(picked);
      out_last_r <= last;
      out_bad_r  <= bad;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.node         = out_node_r;
  assign out_chan.last_of_tour = out_last_r;
  assign out_chan.bad_ordinal  = out_bad_r;

  // The live list never holds more nodes than the tour length.
  a_live_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= count_r)
    else $error("live node count exceeds tour length");

  // Results produced in a tour stay below the tour length.
  a_pos_lt_count: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < count_r)
    else $error("tour position reached tour length");

  // The last request of a tour restarts it with a full list.
  a_tour_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && last && !cfg_wr |=> (pos_r == '0) && (live_r == count_r))
    else $error("tour did not restart after its last request");

  // A good ordinal always picks a real node; a rejected one gives node zero.
  a_node_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bad_r == (out_node_r == '0)))
    else $error("node value disagrees with the error flag");

endmodule
`default_nettype wire

/* verif/ordinal_code_to_permutation_unit_test.sv */
`timescale 1ns / 100ps
module ordinal_code_to_permutation_unit_test import ocp_pkg::*; ();

  // The bench drives every input at the falling clock edge. It samples the outputs at
  // the rising edge, where the registers of the block still hold their old values.
  // A request is counted as taken at a rising edge with valid and ready both high.
  // At that same edge the bench updates its own copy of the node list and queues the
  // result that the request should produce.

  typedef struct packed {
    logic [ORD_W-1:0] node;
    logic             last_of_tour;
    logic             bad_ordinal;
  } tour_result_t;

  typedef enum logic {STEP_ORD, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t   kind;
    logic [31:0]  value;
    logic         typed;
    tour_result_t want;
  } directed_step_t;

  localparam logic [2:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

  localparam int DIRECTED_LEN = 25;

  // Hand-written opening sequence. Rows marked typed carry a result that can be read
  // straight from the rules. The other rows are checked against the list model below.
  localparam directed_step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
    // Tour of 256 nodes after reset: take the last node, then probe the bad ordinals.
    '{STEP_ORD, 32'd256, 1'b1, '{9'd256, 1'b0, 1'b0}},
    '{STEP_ORD, 32'd256, 1'b1, '{9'd0,   1'b0, 1'b1}},
    '{STEP_ORD, 32'd0,   1'b1, '{9'd0,   1'b0, 1'b1}},
    '{STEP_ORD, 32'd511, 1'b1, '{9'd0,   1'b0, 1'b1}},
    '{STEP_ORD, 32'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd1,   1'b1, '{9'd2,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd253, 1'b1, '{9'd255, 1'b0, 1'b0}},
    '{STEP_ORD, 32'd200, 1'b0, '{9'd0,   1'b0, 1'b0}},
    // A write of zero is raised to the minimum tour of two nodes.
    '{STEP_CFG, 32'd0,   1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd2,   1'b1, '{9'd2,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd1,   1'b1, '{9'd1,   1'b1, 1'b0}},
    // A tour made only of bad ordinals still ends after two requests.
    '{STEP_ORD, 32'd0,   1'b1, '{9'd0,   1'b0, 1'b1}},
    '{STEP_ORD, 32'd3,   1'b1, '{9'd0,   1'b1, 1'b1}},
    // A bad ordinal can also be the one that closes the tour.
    '{STEP_ORD, 32'd2,   1'b1, '{9'd2,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd2,   1'b1, '{9'd0,   1'b1, 1'b1}},
    // Only the low nine bits of the write data count, so this sets a tour of three.
    '{STEP_CFG, 32'hFFFF_FE03, 1'b0, '{9'd0, 1'b0, 1'b0}},
    '{STEP_ORD, 32'd2,   1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd2,   1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd1,   1'b0, '{9'd0,   1'b0, 1'b0}},
    // All ones is capped at the largest tour.
    '{STEP_CFG, 32'd511, 1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd128, 1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd128, 1'b0, '{9'd0,   1'b0, 1'b0}},
    // A write in the middle of a tour throws the partial tour away.
    '{STEP_CFG, 32'd1,   1'b0, '{9'd0,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{STEP_ORD, 32'd1,   1'b1, '{9'd2,   1'b1, 1'b0}}
  };

  // The random part runs one phase per tour setting. Small tours dominate, and the two
  // largest settings cover the top of the range. The phases cycle through four idling modes.
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 181;
  localparam int unsigned TOUR_SETTINGS [PHASES] = '{4, 256, 2, 13, 511, 7, 1, 64};

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ocp_in_if  ord_bus ();
  ocp_out_if res_bus ();

  ordinal_code_to_permutation_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (ord_bus),
    .out_chan (res_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Percent chances that the sender skips a cycle and that the receiver stalls one.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  int error_count;

  tour_result_t pending_results [$];

  // The bench keeps its own copy of the list of nodes that have not been chosen yet.
  node_val_t node_list [MAX_NODES];
  int        nodes_left;
  int        tour_pos;
  int        tour_len;

  function automatic void restart_tour();
    for (int i = 0; i < MAX_NODES; i++) begin
      node_list[i] = (i < tour_len) ? node_val_t'(i + 1) : '0;
    end
    tour_pos = 0;
    nodes_left = tour_len;
  endfunction

  // Only the low nine bits of a write count. The tour length is then held within
  // 2..MAX_NODES.
  function automatic void set_tour_length(input logic [31:0] value);
    int w;
    w = int'(value[ORD_W-1:0]);
    if (w < 2) begin
      w = 2;
    end else if (w > MAX_NODES) begin
      w = MAX_NODES;
    end
    tour_len = w;
    restart_tour();
  endfunction

  // Take the k-th remaining node and close the gap after it. A bad ordinal leaves the
  // list alone but still uses up one place in the tour.
  function automatic tour_result_t decode_ordinal(input logic [ORD_W-1:0] ordinal);
    tour_result_t res;
    int slot;
    res = '0;
    res.bad_ordinal = (ordinal == '0) || (int'(ordinal) > nodes_left);
    if (!res.bad_ordinal) begin
      slot = int'(ordinal) - 1;
      res.node = ORD_W'(node_list[slot]);
      for (int i = slot; i + 1 < nodes_left; i++) begin
        node_list[i] = node_list[i + 1];
      end
      node_list[nodes_left - 1] = '0;
      nodes_left--;
    end
    tour_pos++;
    res.last_of_tour = (tour_pos >= tour_len);
    if (res.last_of_tour) begin
      restart_tour();
    end
    return res;
  endfunction

  // Most random ordinals are in range, so that tours run to their end and the list
  // shifts at every depth. The rest hit both ends of the list or are plainly bad.
  function automatic logic [ORD_W-1:0] choose_ordinal();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return ORD_W'($urandom_range(nodes_left, 1));
    if (roll < 78) return ORD_W'(nodes_left);
    if (roll < 84) return ORD_W'(1);
    if (roll < 88) return '0;
    if (roll < 92) return ORD_W'(nodes_left + 1);
    return ORD_W'($urandom_range((1 << ORD_W) - 1));
  endfunction

  function automatic void check_field(input string name, input logic [ORD_W-1:0] want,
                                      input logic [ORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // This task is called at a falling edge and returns at a falling edge. The only
  // assignment it makes to valid in any one step is either the idle one or the send one.
  task automatic send_request(input logic [ORD_W-1:0] ordinal, input logic typed,
                              input tour_result_t typed_res);
    tour_result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      ord_bus.valid <= 1'b0;
      @(negedge clk);
    end
    ord_bus.valid   <= 1'b1;
    ord_bus.ordinal <= ordinal;
    @(posedge clk);
    while (!ord_bus.ready) @(posedge clk);
    predicted = decode_ordinal(ordinal);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Stop sending and wait until every queued result has come out. Each request yields
  // exactly one result, so an empty queue means the block is idle. The extra edges
  // only give margin.
  task automatic drain_results();
    ord_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // The write has a setup phase and an access phase. The register takes the value at
  // the rising edge where the access is seen with pready high. The extra falling edge
  // at the end keeps back-to-back writes from assigning psel twice in one step.
  task automatic write_node_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    set_tour_length(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // The receiver decides again at every falling edge whether to stall the next cycle.
  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result that is taken with the oldest result still owed.
  always @(posedge clk) begin : check_results
    tour_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: node %0d, last_of_tour %0d, bad_ordinal %0d",
               res_bus.node, res_bus.last_of_tour, res_bus.bad_ordinal);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("node", want.node, res_bus.node);
        check_field("last_of_tour", ORD_W'(want.last_of_tour), ORD_W'(res_bus.last_of_tour));
        check_field("bad_ordinal", ORD_W'(want.bad_ordinal), ORD_W'(res_bus.bad_ordinal));
      end
    end
  end

  initial begin : stimulus
    tour_result_t no_result;
    logic [31:0]  cfg_word;
    rst_n           = 1'b0;
    ord_bus.valid   = 1'b0;
    ord_bus.ordinal = '0;
    res_bus.ready   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    no_result       = '0;
    tour_len        = RESET_COUNT;
    restart_tour();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The opening sequence runs with both sides always ready. A register write always
    // waits until the block has emptied.
    for (int s = 0; s < DIRECTED_LEN; s++) begin
      if (DIRECTED_STEPS[s].kind == STEP_CFG) begin
        drain_results();
        write_node_count(DIRECTED_STEPS[s].value);
      end else begin
        send_request(DIRECTED_STEPS[s].value[ORD_W-1:0], DIRECTED_STEPS[s].typed,
                     DIRECTED_STEPS[s].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      // Random upper bits toggle the unused part of the write data.
      cfg_word = ($urandom() & 32'hFFFF_FE00) | TOUR_SETTINGS[p];
      write_node_count(cfg_word);
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_gap_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In odd phases the sender stops halfway until the block has fully emptied.
        if (p % 2 == 1 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_request(choose_ordinal(), 1'b0, no_result);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // A correct run needs about 1500 requests. Even with half of the cycles lost to idling
  // on both sides, plus the drains, two milliseconds leaves a wide margin.
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
